// ===== design/sus_pkg.sv =====
// Shared types and codes for the sorted unique set list.
package sus_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 3;
    localparam int COUNT_W  = 4;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

endpackage

// ===== design/sus_channels.sv =====
// Command and result channel interfaces of the sorted unique set list.
interface sus_cmd_if;
    import sus_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface sus_res_if;
    import sus_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [INDEX_W-1:0]         entry_index;
    logic [COUNT_W-1:0]         held_count;
    logic                       is_empty;
    logic                       is_full;
    logic                       last;

    modport source (output valid, output status, output entry_value, output entry_index,
                     output held_count, output is_empty, output is_full, output last,
                     input ready);
    modport sink (input valid, input status, input entry_value, input entry_index,
                   input held_count, input is_empty, input is_full, input last,
                   output ready);
endinterface

// ===== design/sus_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/sus_cmp.sv =====
// Shared signed compare unit: equality and less-than of an entry against the key.
module sus_cmp (
    input  logic signed [sus_pkg::VALUE_W-1:0] entry,
    input  logic signed [sus_pkg::VALUE_W-1:0] key,
    output sus_pkg::cmp_t                      result
);
    import sus_pkg::*;

    always_comb
    begin
        result.eq = (entry == key);
        result.lt = (entry < key);
    end
endmodule

// ===== design/sorted_unique_set_list.sv =====
// Sorted set of distinct signed values: insert, delete and list under a small sequencer.
//
// Commands arrive on cmd (kind, value); results leave on res through an
// output register. Insert and delete give one result with last set; a list
// gives one result per held entry in ascending order, last on the final one,
// or a single empty result when nothing is held. Every result carries the
// count and the empty and full flags as they stand after the command.
// The entries live in a RAM with registered read, so every step of a scan
// or a shift first addresses the RAM and then compares or writes in the
// state after. An insert scans the held entries, moves up each entry above
// the new value, writes the new value and loads the result; a delete scans
// up to the match, closes up the entries above it and loads the result; a
// list reads and emits each entry in turn. The longest command is an insert
// below every held entry into a set one short of full.
// cmd is ready only while the sequencer is idle. A stalled receiver holds
// the result in the output register; the sequencer runs on and waits only
// where it would load the next result, until the register is free.
// Reset empties the set at once; RAM contents are never read before written.
module sorted_unique_set_list #(
    parameter int CAPACITY = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    sus_cmd_if.sink    cmd,
    sus_res_if.source  res
);
    import sus_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CHK  = 4'd2;
    localparam logic [3:0] S_MOVE_RD   = 4'd3;
    localparam logic [3:0] S_MOVE_WR   = 4'd4;
    localparam logic [3:0] S_PUT       = 4'd5;
    localparam logic [3:0] S_DONE      = 4'd6;
    localparam logic [3:0] S_LIST_RD   = 4'd7;
    localparam logic [3:0] S_LIST_EMIT = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [STATUS_W-1:0]        code_reg, code_next;

    logic                       out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic signed [VALUE_W-1:0]  entry_value_reg, entry_value_next;
    logic [INDEX_W-1:0]         entry_index_reg, entry_index_next;
    logic [COUNT_W-1:0]         held_count_reg, held_count_next;
    logic                       is_empty_reg, is_empty_next;
    logic                       is_full_reg, is_full_next;
    logic                       last_reg, last_next;

    logic                       ram_wr_en, ram_rd_en;
    logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
    logic [VALUE_W-1:0]         ram_wr_data, ram_rd_data;
    logic signed [VALUE_W-1:0]  rd_entry;
    cmp_t                       cmp;

    logic                       out_free;
    logic                       at_last;
    logic [CW-1:0]              pos_scan;

    sus_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = ram_rd_data;

    sus_cmp u_cmp (
        .entry  (rd_entry),
        .key    (value_reg),
        .result (cmp)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign at_last   = (idx_reg == cnt_reg - ONE_C);
    assign pos_scan  = cmp.lt ? idx_reg + ONE_C : pos_reg;
    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        code_next        = code_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        status_next      = status_reg;
        entry_value_next = entry_value_reg;
        entry_index_next = entry_index_reg;
        held_count_next  = held_count_reg;
        is_empty_next    = is_empty_reg;
        is_full_next     = is_full_reg;
        last_next        = last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg[AW-1:0];
        ram_wr_data      = ram_rd_data;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    value_next = cmd.value;
                    idx_next   = '0;
                    pos_next   = '0;
                    code_next  = ST_OK;
                    state_next = S_DONE;
                    case (cmd.kind)
                        KIND_INSERT:
                        begin
                            if (cnt_reg == CAP_C)
                            begin
                                code_next = ST_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                code_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                code_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            code_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    pos_next = pos_scan;
                    if (cmp.eq)
                    begin
                        code_next  = ST_DUP;
                        state_next = S_DONE;
                    end
                    else if (at_last)
                    begin
                        // nothing to move when the new value goes on top
                        if (pos_scan == cnt_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = cnt_reg - ONE_C;
                            state_next = S_MOVE_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_C;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (cmp.eq)
                    begin
                        if (at_last)
                        begin
                            cnt_next   = cnt_reg - ONE_C;
                            code_next  = ST_OK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + ONE_C;
                            state_next = S_MOVE_RD;
                        end
                    end
                    else if (at_last)
                    begin
                        code_next  = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_C;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_MOVE_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                ram_wr_en = 1'b1;
                if (kind_reg == KIND_INSERT)
                begin
                    // shift up, top entry first
                    ram_wr_addr = AW'(idx_reg + ONE_C);
                    if (idx_reg == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ONE_C;
                        state_next = S_MOVE_RD;
                    end
                end
                else
                begin
                    // close the gap, lowest entry first
                    ram_wr_addr = AW'(idx_reg - ONE_C);
                    if (at_last)
                    begin
                        cnt_next   = cnt_reg - ONE_C;
                        code_next  = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_C;
                        state_next = S_MOVE_RD;
                    end
                end
            end

            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[AW-1:0];
                ram_wr_data = value_reg;
                cnt_next    = cnt_reg + ONE_C;
                code_next   = ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = code_reg;
                    entry_value_next = '0;
                    entry_index_next = '0;
                    held_count_next  = COUNT_W'(cnt_reg);
                    is_empty_next    = (cnt_reg == '0);
                    is_full_next     = (cnt_reg == CAP_C);
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_LIST_EMIT;
            end

            S_LIST_EMIT:
            begin
                // read data holds while the receiver stalls
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = ST_OK;
                    entry_value_next = rd_entry;
                    entry_index_next = INDEX_W'(idx_reg);
                    held_count_next  = COUNT_W'(cnt_reg);
                    is_empty_next    = 1'b0;
                    is_full_next     = (cnt_reg == CAP_C);
                    last_next        = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_C;
                        state_next = S_LIST_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        code_reg        <= code_next;
        status_reg      <= status_next;
        entry_value_reg <= entry_value_next;
        entry_index_reg <= entry_index_next;
        held_count_reg  <= held_count_next;
        is_empty_reg    <= is_empty_next;
        is_full_reg     <= is_full_next;
        last_reg        <= last_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.entry_value = entry_value_reg;
    assign res.entry_index = entry_index_reg;
    assign res.held_count  = held_count_reg;
    assign res.is_empty    = is_empty_reg;
    assign res.is_full     = is_full_reg;
    assign res.last        = last_reg;
endmodule

// ===== design/sus_chk.sv =====
// Port-level checker for the sorted unique set list, bound to the top level.
module sus_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [sus_pkg::STATUS_W-1:0]       res_status,
    input logic signed [sus_pkg::VALUE_W-1:0] res_entry_value,
    input logic [sus_pkg::COUNT_W-1:0]        res_held_count,
    input logic                               res_is_empty,
    input logic                               res_is_full,
    input logic                               res_last
);
    import sus_pkg::*;

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_entry_value) && $stable(res_last))
        else $error("result changed while stalled");

    // one command at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_is_empty |-> res_held_count == '0 && !res_is_full)
        else $error("empty flag disagrees with count");

    // rejections are always single results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_last && res_entry_value == '0)
        else $error("rejected command not a single result");
endmodule

bind sorted_unique_set_list sus_chk u_sus_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_entry_value (res.entry_value),
    .res_held_count  (res.held_count),
    .res_is_empty    (res.is_empty),
    .res_is_full     (res.is_full),
    .res_last        (res.last)
);

// ===== tb/sorted_unique_set_list_test.sv =====
// Self-checking testbench for the sorted unique set list: directed table, then random commands.
`timescale 1ns / 100ps

module sorted_unique_set_list_test;
    import sus_pkg::*;

    localparam int SET_CAPACITY  = 8;
    localparam int HALF_PERIOD   = 4;
    localparam int DRAIN_CYCLES  = 4 * SET_CAPACITY + 8;
    localparam int PHASE_ITEMS   = 133;
    localparam int NUM_DIRECTED  = 23;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] entry_value;
        logic [INDEX_W-1:0]        entry_index;
        logic [COUNT_W-1:0]        held_count;
        logic                      is_empty;
        logic                      is_full;
        logic                      last;
    } set_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      fixed;
        logic [STATUS_W-1:0]       status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sus_cmd_if cmd_ch ();
    sus_res_if res_ch ();

    sorted_unique_set_list #(
        .CAPACITY (SET_CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Shadow copy of the set, kept in ascending order
    logic signed [VALUE_W-1:0] held_vals [0:SET_CAPACITY-1];
    int                        held_num;
    set_result_t               pending_results [$];
    int                        error_count;
    int                        snd_idle_pct;
    int                        rcv_idle_pct;
    bit                        fill_mode;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{KIND_LIST,   32'sd0,        1'b1, ST_EMPTY},
        '{KIND_DELETE, 32'sd5,        1'b1, ST_EMPTY},
        '{KIND_INSERT, 32'sd0,        1'b1, ST_OK},
        '{KIND_INSERT, VAL_MIN,       1'b1, ST_OK},
        '{KIND_INSERT, VAL_MAX,       1'b1, ST_OK},
        '{KIND_INSERT, 32'sd0,        1'b1, ST_DUP},
        '{KIND_INSERT, -32'sd1,       1'b0, ST_OK},
        '{KIND_INSERT, 32'sd1,        1'b0, ST_OK},
        '{KIND_DELETE, 32'sd12345,    1'b1, ST_NOTFOUND},
        '{KIND_LIST,   32'sd0,        1'b0, ST_OK},
        '{KIND_INSERT, 32'sh40000000, 1'b0, ST_OK},
        '{KIND_INSERT, 32'shc0000000, 1'b0, ST_OK},
        '{KIND_INSERT, 32'sd7,        1'b0, ST_OK},
        '{KIND_INSERT, 32'sd99,       1'b1, ST_FULL},
        '{KIND_INSERT, 32'sd0,        1'b1, ST_FULL},
        '{KIND_LIST,   32'sh5a5a5a5a, 1'b0, ST_OK},
        '{KIND_UNUSED, 32'sh5a5a5a5a, 1'b1, ST_OK},
        '{KIND_DELETE, VAL_MAX,       1'b0, ST_OK},
        '{KIND_DELETE, VAL_MIN,       1'b0, ST_OK},
        '{KIND_DELETE, 32'sd0,        1'b0, ST_OK},
        '{KIND_DELETE, 32'sd99,       1'b1, ST_NOTFOUND},
        '{KIND_LIST,   -32'sd1,       1'b0, ST_OK},
        '{KIND_UNUSED, -32'sd1,       1'b1, ST_OK}
    };

    always #(HALF_PERIOD) clk = ~clk;

    function automatic set_result_t make_result(input logic [STATUS_W-1:0] st,
                                                input logic signed [VALUE_W-1:0] val,
                                                input int idx, input logic is_last);
        set_result_t r;
        r.status      = st;
        r.entry_value = val;
        r.entry_index = idx[INDEX_W-1:0];
        r.held_count  = held_num[COUNT_W-1:0];
        r.is_empty    = (held_num == 0);
        r.is_full     = (held_num >= SET_CAPACITY);
        r.last        = is_last;
        return r;
    endfunction

    // Apply one command to the shadow set and queue the results it should give
    function automatic void apply_set_command(input logic [KIND_W-1:0] k,
                                              input logic signed [VALUE_W-1:0] v,
                                              input logic fixed,
                                              input logic [STATUS_W-1:0] fixed_status);
        logic [STATUS_W-1:0] st;
        int pos;
        int i;
        st = ST_OK;
        case (k)
            KIND_INSERT:
            begin
                if (held_num >= SET_CAPACITY)
                    st = ST_FULL;
                else
                begin
                    pos = 0;
                    for (i = 0; i < held_num; i++)
                    begin
                        if (held_vals[i] == v)
                            st = ST_DUP;
                        if (held_vals[i] < v)
                            pos = i + 1;
                    end
                    if (st == ST_OK)
                    begin
                        for (i = held_num; i > pos; i--)
                            held_vals[i] = held_vals[i-1];
                        held_vals[pos] = v;
                        held_num++;
                    end
                end
            end
            KIND_DELETE:
            begin
                if (held_num == 0)
                    st = ST_EMPTY;
                else
                begin
                    pos = -1;
                    for (i = 0; i < held_num; i++)
                        if (pos < 0 && held_vals[i] == v)
                            pos = i;
                    if (pos < 0)
                        st = ST_NOTFOUND;
                    else
                    begin
                        for (i = pos; i + 1 < held_num; i++)
                            held_vals[i] = held_vals[i+1];
                        held_num--;
                    end
                end
            end
            KIND_LIST:
            begin
                if (held_num == 0)
                    st = ST_EMPTY;
                else
                begin
                    for (i = 0; i < held_num; i++)
                        pending_results.push_back(make_result(ST_OK, held_vals[i], i,
                                                              i + 1 == held_num));
                    return;
                end
            end
            default: ;
        endcase
        if (fixed)
            st = fixed_status;
        pending_results.push_back(make_result(st, '0, 0, 1'b1));
    endfunction

    // Hold valid until the transfer; readiness is sampled mid-cycle to stay clear of the edge
    task automatic send_command(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v,
                                input logic fixed, input logic [STATUS_W-1:0] fixed_status);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= k;
        cmd_ch.value <= v;
        do
            @(negedge clk);
        while (!cmd_ch.ready);
        apply_set_command(k, v, fixed, fixed_status);
        @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3, 4, 5: return $signed($urandom_range(15)) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_random_commands(input int count);
        logic [KIND_W-1:0]         k;
        logic signed [VALUE_W-1:0] v;
        int                        roll;
        for (int n = 0; n < count; n++)
        begin
            // Swing between filling and draining so full and empty are both reached often
            if (fill_mode && held_num == SET_CAPACITY && $urandom_range(3) == 0)
                fill_mode = 1'b0;
            else if (!fill_mode && held_num == 0 && $urandom_range(3) == 0)
                fill_mode = 1'b1;
            roll = $urandom_range(99);
            if (roll < 4)
                k = KIND_UNUSED;
            else if (roll < 17)
                k = KIND_LIST;
            else if (roll < (fill_mode ? 37 : 82))
                k = KIND_DELETE;
            else
                k = KIND_INSERT;
            v = pick_value();
            if (k == KIND_DELETE && held_num > 0 && $urandom_range(99) < 60)
                v = held_vals[$urandom_range(held_num - 1)];
            send_command(k, v, 1'b0, ST_OK);
        end
    endtask

    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);

    always @(negedge clk)
    begin
        set_result_t got;
        set_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.status, res_ch.entry_value, res_ch.entry_index, res_ch.held_count,
                    res_ch.is_empty, res_ch.is_full, res_ch.last};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status=%0d value=%0d index=%0d count=%0d",
                         $time, got.status, got.entry_value, got.entry_index, got.held_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch", $time);
                    $write("    expected status=%0d value=%0d index=%0d count=%0d",
                           want.status, want.entry_value, want.entry_index, want.held_count);
                    $display(" empty=%0b full=%0b last=%0b",
                             want.is_empty, want.is_full, want.last);
                    $write("    actual   status=%0d value=%0d index=%0d count=%0d",
                           got.status, got.entry_value, got.entry_index, got.held_count);
                    $display(" empty=%0b full=%0b last=%0b",
                             got.is_empty, got.is_full, got.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind  = KIND_INSERT;
        cmd_ch.value = '0;
        held_num     = 0;
        error_count  = 0;
        fill_mode    = 1'b1;
        snd_idle_pct = 27;
        rcv_idle_pct = 75;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_command(directed_rows[r].kind, directed_rows[r].value,
                         directed_rows[r].fixed, directed_rows[r].status);
        send_random_commands(PHASE_ITEMS);

        snd_idle_pct = 75;
        rcv_idle_pct = 27;
        send_random_commands(PHASE_ITEMS);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random_commands(PHASE_ITEMS);
        cmd_ch.valid <= 1'b0;

        // Drain, then give any stray result time to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
